// ----- hw/rtl/tset_pkg.sv -----
package tset_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
	localparam int KEY_W  = 34;
	localparam int NOTE_W = 16;

	localparam logic [13:0] MAX_YEAR   = 14'd9999;
	localparam logic [3:0]  MAX_MONTH  = 4'd12;
	localparam logic [4:0]  MAX_HOUR   = 5'd23;
	localparam logic [5:0]  MAX_MINUTE = 6'd59;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [15:0] note_tag;
		logic [6:0]  position;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [6:0]  entry_count;
		logic [6:0]  slot;
		logic [13:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [4:0]  out_hour;
		logic [5:0]  out_minute;
		logic [15:0] out_note_tag;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [NOTE_W-1:0] note;
	} entry_t;

	typedef struct packed {
		logic             ins;
		logic             del;
		entry_t           fresh;
		logic [CNT_W-1:0] count;
		logic [IDX_W-1:0] del_idx;
	} cell_cmd_t;

endpackage

// ----- hw/rtl/tset_cell.sv -----
module tset_cell import tset_pkg::*; (
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic [IDX_W-1:0] idx,
	input  logic             last,
	input  entry_t           prev,
	input  logic             prev_gt,
	input  entry_t           next,
	output entry_t           entry_q,
	output logic             gt
);

	logic occ;

	assign occ = CNT_W'(idx) < cmd.count;
	// empty cells count as greater, so the row reads as a thermometer
	assign gt  = !occ || (entry_q.key > cmd.fresh.key);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (prev_gt) begin
				entry_q <= prev;
			end else if (gt) begin
				entry_q <= cmd.fresh;
			end
		end else if (cmd.del && !last && idx >= cmd.del_idx) begin
			entry_q <= next;
		end
	end

endmodule

// ----- hw/rtl/tset_chain.sv -----
module tset_chain import tset_pkg::*; (
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [IDX_W-1:0] ins_idx,
	output entry_t           rd_entry
);

	entry_t ent [DEPTH];
	logic   gt  [DEPTH];
	logic   bnd [DEPTH];
	logic [$bits(entry_t)-1:0] rd_bits;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_gt;

		if (g == 0) begin : g_first
			assign prev_e  = cmd.fresh;
			assign prev_gt = 1'b0;
		end else begin : g_mid
			assign prev_e  = ent[g-1];
			assign prev_gt = gt[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign next_e = ent[g];
		end else begin : g_inner
			assign next_e = ent[g+1];
		end

		assign bnd[g] = gt[g] & ~prev_gt;

		tset_cell u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.idx     (IDX_W'(g)),
			.last    (g == DEPTH - 1),
			.prev    (prev_e),
			.prev_gt (prev_gt),
			.next    (next_e),
			.entry_q (ent[g]),
			.gt      (gt[g])
		);
	end

	always_comb begin
		ins_idx = '0;
		rd_bits = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (bnd[i]) begin
				ins_idx = ins_idx | IDX_W'(i);
			end
			if (rd_idx == IDX_W'(i)) begin
				rd_bits = rd_bits | ent[i];
			end
		end
	end

	assign rd_entry = rd_bits;

endmodule

// ----- hw/rtl/timestamp_sorted_event_table_core.sv -----
// Sorted event table: up to DEPTH entries kept in ascending order of
// (year, month, day, hour, minute), each with a 16-bit note handle.
//
// Request channel req (req_valid / req_stall) carries one word per operation:
// insert, delete at a 1-based position, or read at a position. The response
// channel rsp (rsp_valid / rsp_stall) returns exactly one word per request,
// with status, the entry count after the operation, the slot touched and,
// for a read, the stored entry.
//
// rsp_valid rises once a taken request has passed the input register and the
// response register: while the word sits in the input register, the row of
// cells compares every stored key with the new one in parallel and shifts in
// place, and the response register captures the result. Throughput is one
// word per cycle while rsp is taken.
//
// Reset clears the entry count and both valid flags; the table contents are
// not cleared and need not be. While rsp_stall is high the response word holds,
// one further request is captured, and req_stall then rises until rsp drains.
module timestamp_sorted_event_table_core import tset_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	req_t             req_s1;
	logic             vld_s1;
	rsp_t             rsp_q;
	logic             rsp_valid_q;
	logic [CNT_W-1:0] count_q;

	logic             exec;
	logic             take;
	logic             range_bad;
	logic             full;
	logic             pos_bad;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic [CMP_W-1:0] pos_m1;
	logic [CMP_W-1:0] ins_slot;
	logic [CMP_W-1:0] cnt_n_w;
	logic [CNT_W-1:0] count_n;
	logic [IDX_W-1:0] ins_idx;
	entry_t           rd_entry;
	cell_cmd_t        cmd;
	rsp_t             rsp_n;

	assign exec      = vld_s1 & (~rsp_valid_q | ~rsp_stall);
	assign req_stall = vld_s1 & ~exec;
	assign take      = req_valid & ~req_stall;

	assign range_bad = (req_s1.year > MAX_YEAR) || (req_s1.month == '0) ||
		(req_s1.month > MAX_MONTH) || (req_s1.day == '0) ||
		(req_s1.hour > MAX_HOUR) || (req_s1.minute > MAX_MINUTE);
	assign full      = count_q == CNT_W'(DEPTH);
	assign pos_w     = CMP_W'(req_s1.position);
	assign cnt_w     = CMP_W'(count_q);
	assign pos_bad   = (pos_w == '0) || (pos_w > cnt_w);
	assign pos_m1    = pos_w - CMP_W'(1);

	assign cmd.ins         = exec && (req_s1.opcode == OP_INSERT) && !range_bad && !full;
	assign cmd.del         = exec && (req_s1.opcode == OP_DELETE) && !pos_bad;
	assign cmd.fresh.key   = {req_s1.year, req_s1.month, req_s1.day, req_s1.hour,
		req_s1.minute};
	assign cmd.fresh.note  = req_s1.note_tag;
	assign cmd.count       = count_q;
	assign cmd.del_idx     = pos_m1[IDX_W-1:0];

	tset_chain u_chain (
		.clk      (clk),
		.cmd      (cmd),
		.rd_idx   (pos_m1[IDX_W-1:0]),
		.ins_idx  (ins_idx),
		.rd_entry (rd_entry)
	);

	assign ins_slot = CMP_W'(ins_idx) + CMP_W'(1);
	assign count_n  = cmd.ins ? count_q + CNT_W'(1) :
		cmd.del ? count_q - CNT_W'(1) : count_q;
	assign cnt_n_w  = CMP_W'(count_n);

	always_comb begin
		rsp_n             = '0;
		rsp_n.entry_count = cnt_n_w[6:0];
		case (req_s1.opcode)
			OP_INSERT: begin
				if (range_bad) begin
					rsp_n.status = ST_RANGE;
				end else if (full) begin
					rsp_n.status = ST_FULL;
				end else begin
					rsp_n.status = ST_OK;
					rsp_n.slot   = ins_slot[6:0];
				end
			end
			OP_DELETE: begin
				if (pos_bad) begin
					rsp_n.status = ST_BAD_POS;
				end else begin
					rsp_n.status = ST_OK;
					rsp_n.slot   = req_s1.position;
				end
			end
			OP_READ: begin
				if (pos_bad) begin
					rsp_n.status = ST_BAD_POS;
				end else begin
					rsp_n.status       = ST_OK;
					rsp_n.slot         = req_s1.position;
					rsp_n.out_year     = rd_entry.key[33:20];
					rsp_n.out_month    = rd_entry.key[19:16];
					rsp_n.out_day      = rd_entry.key[15:11];
					rsp_n.out_hour     = rd_entry.key[10:6];
					rsp_n.out_minute   = rd_entry.key[5:0];
					rsp_n.out_note_tag = rd_entry.note;
				end
			end
			default: begin
				rsp_n.status = ST_RANGE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (exec) begin
				vld_s1 <= 1'b0;
			end
			if (exec) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
		end
		if (exec) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hw/rtl/tset_checker.sv -----
module tset_checker import tset_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("request word changed while stalled");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	a_err_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.slot == 7'd0)
		else $error("error response carries a slot");

	a_ok_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_OK |-> rsp.slot != 7'd0)
		else $error("successful response without a slot");

	a_read_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.out_month != 4'd0 || rsp.out_day != 5'd0) |->
		rsp.status == ST_OK && rsp.slot != 7'd0)
		else $error("entry data on a response that is not a read");

endmodule

bind timestamp_sorted_event_table_core tset_checker u_tset_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ----- sim/timestamp_sorted_event_table_core_tb.sv -----
`timescale 1ns / 1ps

module timestamp_sorted_event_table_core_tb;
	import tset_pkg::*;

	localparam int         RANDOM_WORDS   = 1800;
	localparam int         CALM_WORDS     = 200;
	localparam int         HOLD_CYCLES    = 60;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         SETTLE_CYCLES  = 8;
	localparam int         REPORT_LIMIT   = 10;
	localparam logic [1:0] OP_UNUSED      = 2'd3;

	typedef enum logic [1:0] {
		TREND_FILL,
		TREND_DRAIN,
		TREND_MIX
	} trend_t;

	typedef struct {
		req_t word;
		bit   typed;
		rsp_t want;
	} script_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	entry_t      event_rows [DEPTH];
	int          stored      = 0;
	rsp_t        awaited [$];
	script_row_t script [$];
	int          fault_count = 0;
	bit          calm        = 1'b0;
	bit          long_hold   = 1'b0;

	timestamp_sorted_event_table_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	function automatic rsp_t apply_to_table(input req_t w);
		rsp_t             r;
		logic [KEY_W-1:0] k;
		entry_t           e;
		int               at;
		r = '0;
		case (w.opcode)
			OP_INSERT: begin
				if (w.year > MAX_YEAR || w.month == 4'd0 || w.month > MAX_MONTH ||
						w.day == 5'd0 || w.hour > MAX_HOUR || w.minute > MAX_MINUTE) begin
					r.status = ST_RANGE;
				end else if (stored >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					k  = {w.year, w.month, w.day, w.hour, w.minute};
					at = stored;
					for (int i = stored - 1; i >= 0; i--)
						if (event_rows[i].key > k)
							at = i;
					for (int i = stored; i > at; i--)
						event_rows[i] = event_rows[i - 1];
					event_rows[at].key  = k;
					event_rows[at].note = w.note_tag;
					stored++;
					r.status = ST_OK;
					r.slot   = 7'(at + 1);
				end
			end
			OP_DELETE: begin
				if (w.position == 7'd0 || w.position > stored) begin
					r.status = ST_BAD_POS;
				end else begin
					for (int i = w.position - 1; i < stored - 1; i++)
						event_rows[i] = event_rows[i + 1];
					stored--;
					r.status = ST_OK;
					r.slot   = w.position;
				end
			end
			OP_READ: begin
				if (w.position == 7'd0 || w.position > stored) begin
					r.status = ST_BAD_POS;
				end else begin
					e              = event_rows[w.position - 1];
					r.status       = ST_OK;
					r.slot         = w.position;
					r.out_year     = e.key[33:20];
					r.out_month    = e.key[19:16];
					r.out_day      = e.key[15:11];
					r.out_hour     = e.key[10:6];
					r.out_minute   = e.key[5:0];
					r.out_note_tag = e.note;
				end
			end
			default: begin
				r.status = ST_RANGE;
			end
		endcase
		r.entry_count = 7'(stored);
		return r;
	endfunction

	function automatic req_t insert_word(input int y, input int mo, input int d, input int h,
			input int mi, input int note);
		req_t w;
		w          = '0;
		w.opcode   = OP_INSERT;
		w.year     = 14'(y);
		w.month    = 4'(mo);
		w.day      = 5'(d);
		w.hour     = 5'(h);
		w.minute   = 6'(mi);
		w.note_tag = 16'(note);
		return w;
	endfunction

	function automatic req_t position_word(input logic [1:0] op, input int pos);
		req_t w;
		w          = '0;
		w.opcode   = op;
		w.position = 7'(pos);
		return w;
	endfunction

	function automatic rsp_t status_word(input status_t st, input int cnt, input int slot);
		rsp_t r;
		r             = '0;
		r.status      = st;
		r.entry_count = 7'(cnt);
		r.slot        = 7'(slot);
		return r;
	endfunction

	function automatic req_t random_word(input trend_t trend);
		req_t w;
		int   pick;
		int   ins_pct;
		int   del_pct;
		w.opcode   = OP_READ;
		w.year     = 14'($urandom_range(0, 9999));
		w.month    = 4'($urandom_range(1, 12));
		w.day      = 5'($urandom_range(1, 31));
		w.hour     = 5'($urandom_range(0, 23));
		w.minute   = 6'($urandom_range(0, 59));
		w.note_tag = 16'($urandom_range(0, 65535));
		w.position = 7'($urandom_range(0, 127));
		// narrow key pool so that equal keys pile up
		if ($urandom_range(0, 2) == 0) begin
			w.year   = 14'($urandom_range(2000, 2001));
			w.month  = 4'($urandom_range(1, 2));
			w.day    = 5'($urandom_range(1, 2));
			w.hour   = 5'($urandom_range(0, 1));
			w.minute = 6'($urandom_range(0, 1));
		end
		case (trend)
			TREND_FILL: begin
				ins_pct = 70;
				del_pct = 10;
			end
			TREND_DRAIN: begin
				ins_pct = 15;
				del_pct = 65;
			end
			default: begin
				ins_pct = 40;
				del_pct = 30;
			end
		endcase
		pick = $urandom_range(0, 99);
		if (pick < ins_pct) begin
			w.opcode = OP_INSERT;
		end else if (pick < 95) begin
			w.opcode = (pick < ins_pct + del_pct) ? OP_DELETE : OP_READ;
			if ($urandom_range(0, 7) != 0)
				w.position = (stored == 0) ? 7'd1 : 7'($urandom_range(1, stored));
		end else begin
			case ($urandom_range(0, 2))
				0: begin
					w.opcode = OP_UNUSED;
				end
				1: begin
					w.opcode = OP_INSERT;
					w.year   = 14'($urandom_range(0, 16383));
					w.month  = 4'($urandom_range(0, 15));
					w.day    = 5'($urandom_range(0, 31));
					w.hour   = 5'($urandom_range(0, 31));
					w.minute = 6'($urandom_range(0, 63));
				end
				default: begin
					w.opcode = $urandom_range(0, 1) ? OP_DELETE : OP_READ;
				end
			endcase
		end
		return w;
	endfunction

	task automatic offer_word(input req_t w, input bit typed, input rsp_t want);
		rsp_t predicted;
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predicted = apply_to_table(w);
		awaited.push_back(typed ? want : predicted);
		if (!calm && !long_hold && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("unexpected response word %h", rsp);
			end else begin
				want = awaited.pop_front();
				if (rsp.status !== want.status || rsp.entry_count !== want.entry_count ||
						rsp.slot !== want.slot || rsp.out_year !== want.out_year ||
						rsp.out_month !== want.out_month || rsp.out_day !== want.out_day ||
						rsp.out_hour !== want.out_hour || rsp.out_minute !== want.out_minute ||
						rsp.out_note_tag !== want.out_note_tag) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT) begin
						$display("response mismatch: exp st=%0d cnt=%0d slot=%0d %0d-%0d-%0d %0d:%0d note=%h",
							want.status, want.entry_count, want.slot, want.out_year,
							want.out_month, want.out_day, want.out_hour, want.out_minute,
							want.out_note_tag);
						$display("                   got st=%0d cnt=%0d slot=%0d %0d-%0d-%0d %0d:%0d note=%h",
							rsp.status, rsp.entry_count, rsp.slot,
							rsp.out_year, rsp.out_month, rsp.out_day, rsp.out_hour,
							rsp.out_minute, rsp.out_note_tag);
					end
				end
			end
		end
	end

	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else if (calm) begin
				rsp_stall <= 1'b0;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		trend_t trend;
		int     mix_left;
		req_t   ones;
		ones     = '1;
		trend    = TREND_FILL;
		mix_left = 0;

		script.push_back('{position_word(OP_READ, 1), 1'b1, status_word(ST_BAD_POS, 0, 0)});
		script.push_back('{position_word(OP_DELETE, 0), 1'b1, status_word(ST_BAD_POS, 0, 0)});
		script.push_back('{ones, 1'b1, status_word(ST_RANGE, 0, 0)});
		script.push_back('{insert_word(16383, 1, 1, 0, 0, 0), 1'b1, status_word(ST_RANGE, 0, 0)});
		script.push_back('{insert_word(0, 0, 1, 0, 0, 0), 1'b1, status_word(ST_RANGE, 0, 0)});
		script.push_back('{insert_word(0, 13, 1, 0, 0, 0), 1'b1, status_word(ST_RANGE, 0, 0)});
		script.push_back('{insert_word(0, 1, 0, 0, 0, 0), 1'b1, status_word(ST_RANGE, 0, 0)});
		script.push_back('{insert_word(0, 1, 1, 24, 0, 0), 1'b1, status_word(ST_RANGE, 0, 0)});
		script.push_back('{insert_word(0, 1, 1, 0, 60, 0), 1'b1, status_word(ST_RANGE, 0, 0)});
		script.push_back('{insert_word(0, 1, 1, 0, 0, 0), 1'b1, status_word(ST_OK, 1, 1)});
		script.push_back('{insert_word(9999, 12, 31, 23, 59, 65535), 1'b1,
			status_word(ST_OK, 2, 2)});
		script.push_back('{insert_word(2024, 6, 15, 12, 30, 4660), 1'b0, '0});
		script.push_back('{insert_word(0, 1, 1, 0, 0, 21845), 1'b0, '0});
		script.push_back('{position_word(OP_READ, 1), 1'b0, '0});
		script.push_back('{position_word(OP_READ, 2), 1'b0, '0});
		script.push_back('{position_word(OP_READ, 4), 1'b0, '0});
		script.push_back('{position_word(OP_READ, 5), 1'b1, status_word(ST_BAD_POS, 4, 0)});
		script.push_back('{position_word(OP_READ, 127), 1'b1, status_word(ST_BAD_POS, 4, 0)});
		script.push_back('{position_word(OP_DELETE, 4), 1'b1, status_word(ST_OK, 3, 4)});
		script.push_back('{position_word(OP_DELETE, 1), 1'b1, status_word(ST_OK, 2, 1)});
		script.push_back('{position_word(OP_READ, 1), 1'b0, '0});
		script.push_back('{position_word(OP_READ, 0), 1'b1, status_word(ST_BAD_POS, 2, 0)});
		script.push_back('{position_word(OP_DELETE, 2), 1'b1, status_word(ST_OK, 1, 2)});
		script.push_back('{position_word(OP_DELETE, 1), 1'b1, status_word(ST_OK, 0, 1)});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			offer_word(script[i].word, script[i].typed, script[i].want);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			calm = (n >= RANDOM_WORDS - CALM_WORDS);
			// hold the response side back so the block backs up
			if (n == 300 || n == 1000)
				long_hold = 1'b1;
			offer_word(random_word(trend), 1'b0, '0);
			case (trend)
				TREND_FILL: begin
					if (stored == DEPTH && $urandom_range(0, 5) == 0)
						trend = TREND_DRAIN;
				end
				TREND_DRAIN: begin
					if (stored == 0) begin
						trend    = TREND_MIX;
						mix_left = $urandom_range(50, 150);
					end
				end
				default: begin
					mix_left--;
					if (mix_left <= 0)
						trend = TREND_FILL;
				end
			endcase
		end
		req_valid <= 1'b0;

		while (awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
